// ===== src/ppts_pkg.sv =====
// ----------------------------------------------------------------------------
// ppts_pkg
// Shared constants and a saturation function for the point projection to screen block.
// ----------------------------------------------------------------------------
`default_nettype none
package ppts_pkg;
    localparam int FRAC_BITS_DEF = 16;
    localparam int CFG_W = 13;
    localparam int TXT_W = 12;

    localparam logic [1:0] REG_VP_W = 2'd0;
    localparam logic [1:0] REG_VP_H = 2'd1;
    localparam logic [1:0] REG_SC_W = 2'd2;
    localparam logic [1:0] REG_SC_H = 2'd3;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_XFRM = 1'b1;

    function automatic logic signed [31:0] sat64(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            sat64 = 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            sat64 = 32'sh80000000;
        end else begin
            sat64 = v[31:0];
        end
    endfunction
endpackage
`default_nettype wire

// ===== src/ppts_lane.sv =====
// ----------------------------------------------------------------------------
// ppts_lane
// One matrix row: four registered products, shifted and summed, saturated.
// ----------------------------------------------------------------------------
`default_nettype none
module ppts_lane #(
    parameter int FRAC_BITS = ppts_pkg::FRAC_BITS_DEF
) (
    input  wire               aclk,
    input  wire signed [31:0] m0,
    input  wire signed [31:0] m1,
    input  wire signed [31:0] m2,
    input  wire signed [31:0] m3,
    input  wire signed [31:0] v0,
    input  wire signed [31:0] v1,
    input  wire signed [31:0] v2,
    input  wire signed [31:0] v3,
    output logic signed [31:0] dot
);
    logic signed [63:0] p_reg [4];
    logic signed [63:0] t [4];
    logic signed [63:0] sum;

    always_ff @(posedge aclk) begin
        p_reg[0] <= m0 * v0;
        p_reg[1] <= m1 * v1;
        p_reg[2] <= m2 * v2;
        p_reg[3] <= m3 * v3;
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            t[i] = p_reg[i] >>> FRAC_BITS;
        end
        sum = t[0] + t[1] + t[2] + t[3];
        dot = ppts_pkg::sat64(sum);
    end
endmodule
`default_nettype wire

// ===== src/ppts_div.sv =====
// ----------------------------------------------------------------------------
// ppts_div
// Restoring divider: (num << FRAC_BITS) / den, truncated, saturated.
// ----------------------------------------------------------------------------
`default_nettype none
module ppts_div #(
    parameter int FRAC_BITS = ppts_pkg::FRAC_BITS_DEF
) (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               start,
    input  wire signed [31:0] num,
    input  wire signed [31:0] den,
    output logic              done,
    output logic signed [31:0] quo
);
    localparam int NW = 32 + FRAC_BITS;
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] n_reg, n_next;
    logic [NW-1:0] q_reg, q_next;
    logic [32:0]   r_reg, r_next;
    logic [31:0]   d_reg;
    logic          neg_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic [33:0]   trial;
    logic signed [NW:0] sq;

    always_comb begin
        trial  = {r_reg, n_reg[NW-1]} - {2'b0, d_reg};
        n_next = n_reg << 1;
        if (!trial[33]) begin
            r_next = trial[32:0];
            q_next = {q_reg[NW-2:0], 1'b1};
        end else begin
            r_next = {r_reg[31:0], n_reg[NW-1]};
            q_next = {q_reg[NW-2:0], 1'b0};
        end
        sq  = neg_reg ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});
        quo = ppts_pkg::sat64(64'(sq));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NW);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            n_reg   <= NW'(num[31] ? 33'(-$signed({num[31], num})) : 33'(num)) << FRAC_BITS;
            d_reg   <= den[31] ? 32'(-den) : den;
            neg_reg <= num[31] ^ den[31];
            q_reg   <= '0;
            r_reg   <= '0;
        end else if (busy_reg) begin
            n_reg <= n_next;
            q_reg <= q_next;
            r_reg <= r_next;
        end
    end
endmodule
`default_nettype wire

// ===== src/point_projection_to_screen_core.sv =====
// ----------------------------------------------------------------------------
// point_projection_to_screen_core
// Loads matrix rows and projects points to clamped screen positions.
// ----------------------------------------------------------------------------
// A load word gives no result. A point word runs through four parallel row
// lanes twice (modelview, then projection), then three divides in turn on one
// bit-serial divider (start, 32+FRAC_BITS steps, done), then map and clamp.
// A point whose projected w is zero skips the divides, map and clamp. One word
// at a time.
`default_nettype none
module point_projection_to_screen_core #(
    parameter int FRAC_BITS = ppts_pkg::FRAC_BITS_DEF
) (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               s_valid,
    output logic              s_ready,
    input  wire               s_mode,
    input  wire               s_which_matrix,
    input  wire [1:0]         s_row_index,
    input  wire signed [31:0] s_a0,
    input  wire signed [31:0] s_a1,
    input  wire signed [31:0] s_a2,
    input  wire signed [31:0] s_a3,
    input  wire [11:0]        s_text_width,
    input  wire [11:0]        s_text_height,
    output logic              m_valid,
    input  wire               m_ready,
    output logic signed [31:0] m_screen_x,
    output logic signed [31:0] m_screen_y,
    output logic signed [31:0] m_depth,
    output logic              m_w_zero,
    input  wire               cfg_valid,
    output logic              cfg_ready,
    input  wire [1:0]         cfg_index,
    input  wire [12:0]        cfg_data
);
    localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_MV0  = 4'd1;
    localparam logic [3:0] ST_MV1  = 4'd2;
    localparam logic [3:0] ST_PJ0  = 4'd3;
    localparam logic [3:0] ST_PJ1  = 4'd4;
    localparam logic [3:0] ST_DIV  = 4'd5;
    localparam logic [3:0] ST_MAP  = 4'd6;
    localparam logic [3:0] ST_CLMP = 4'd7;
    localparam logic [3:0] ST_OUT  = 4'd8;

    logic [3:0] st_reg;
    logic signed [31:0] mv_reg [16];
    logic signed [31:0] pj_reg [16];
    logic [12:0] vpw_reg, vph_reg, scw_reg, sch_reg;
    logic signed [31:0] v_reg [4];
    logic [11:0] tw_reg, th_reg;
    logic signed [31:0] q_reg [3];
    logic [1:0] dsel_reg;
    logic signed [63:0] mx_reg, my_reg;
    logic signed [31:0] dz_reg;
    logic signed [31:0] lane_out [4];
    logic use_pj;
    logic div_start, div_done;
    logic signed [31:0] div_quo, div_num;

    assign use_pj = (st_reg == ST_PJ0) || (st_reg == ST_PJ1);
    assign s_ready = (st_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    genvar g;
    generate
        for (g = 0; g < 4; g++) begin : g_lane
            ppts_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
                .aclk(aclk),
                .m0(use_pj ? pj_reg[g*4]   : mv_reg[g*4]),
                .m1(use_pj ? pj_reg[g*4+1] : mv_reg[g*4+1]),
                .m2(use_pj ? pj_reg[g*4+2] : mv_reg[g*4+2]),
                .m3(use_pj ? pj_reg[g*4+3] : mv_reg[g*4+3]),
                .v0(v_reg[0]), .v1(v_reg[1]), .v2(v_reg[2]), .v3(v_reg[3]),
                .dot(lane_out[g])
            );
        end
    endgenerate

    always_comb begin
        case (dsel_reg)
            2'd0:    div_num = v_reg[0];
            2'd1:    div_num = v_reg[1];
            default: div_num = v_reg[2];
        endcase
    end

    ppts_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .num(div_num), .den(v_reg[3]), .done(div_done), .quo(div_quo)
    );

    // clamp math, exact widths
    logic signed [47:0] half_fx, hix, sx_c, sy_c, hiy;
    logic signed [15:0] hx_int, hy_int;
    always_comb begin
        hx_int  = $signed({3'b0, scw_reg}) - $signed({4'b0, tw_reg[11:1]});
        half_fx = 48'($signed({5'b0, tw_reg[11:1]})) <<< FRAC_BITS;
        hix     = 48'(hx_int) <<< FRAC_BITS;
        if (48'(mx_reg) < half_fx) sx_c = half_fx;
        else if (48'(mx_reg) > hix) sx_c = hix;
        else sx_c = 48'(mx_reg);
        hy_int = $signed({3'b0, sch_reg}) - 16'($signed({2'b0, th_reg, 2'b0}) + $signed({4'b0, th_reg}));
        hiy    = 48'(hy_int) <<< FRAC_BITS;
        if (my_reg < 0) sy_c = '0;
        else if (48'(my_reg) > hiy) sy_c = hiy;
        else sy_c = 48'(my_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 16; i++) begin
                mv_reg[i] <= (i % 5 == 0) ? ONE : '0;
                pj_reg[i] <= (i % 5 == 0) ? ONE : '0;
            end
            vpw_reg <= 13'd1024; vph_reg <= 13'd768;
            scw_reg <= 13'd1024; sch_reg <= 13'd768;
            st_reg <= ST_IDLE; m_valid <= 1'b0; div_start <= 1'b0;
            dsel_reg <= '0;
        end else begin
            div_start <= 1'b0;
            if (cfg_valid) begin
                unique case (cfg_index)
                    ppts_pkg::REG_VP_W: vpw_reg <= cfg_data;
                    ppts_pkg::REG_VP_H: vph_reg <= cfg_data;
                    ppts_pkg::REG_SC_W: scw_reg <= cfg_data;
                    default:            sch_reg <= cfg_data;
                endcase
            end
            unique case (st_reg)
                ST_IDLE: if (s_valid) begin
                    v_reg[0] <= s_a0; v_reg[1] <= s_a1;
                    v_reg[2] <= s_a2; v_reg[3] <= s_a3;
                    tw_reg <= s_text_width; th_reg <= s_text_height;
                    if (s_mode == ppts_pkg::MODE_LOAD) begin
                        if (s_which_matrix) begin
                            pj_reg[{s_row_index, 2'd0}] <= s_a0;
                            pj_reg[{s_row_index, 2'd1}] <= s_a1;
                            pj_reg[{s_row_index, 2'd2}] <= s_a2;
                            pj_reg[{s_row_index, 2'd3}] <= s_a3;
                        end else begin
                            mv_reg[{s_row_index, 2'd0}] <= s_a0;
                            mv_reg[{s_row_index, 2'd1}] <= s_a1;
                            mv_reg[{s_row_index, 2'd2}] <= s_a2;
                            mv_reg[{s_row_index, 2'd3}] <= s_a3;
                        end
                    end else begin
                        st_reg <= ST_MV0;
                    end
                end
                ST_MV0: st_reg <= ST_MV1;
                ST_MV1: begin
                    for (int i = 0; i < 4; i++) v_reg[i] <= lane_out[i];
                    st_reg <= ST_PJ0;
                end
                ST_PJ0: st_reg <= ST_PJ1;
                ST_PJ1: begin
                    for (int i = 0; i < 4; i++) v_reg[i] <= lane_out[i];
                    if (lane_out[3] == 0) begin
                        m_screen_x <= '0; m_screen_y <= '0; m_depth <= '0;
                        m_w_zero <= 1'b1; m_valid <= 1'b1;
                        st_reg <= ST_OUT;
                    end else begin
                        dsel_reg <= 2'd0; div_start <= 1'b1;
                        st_reg <= ST_DIV;
                    end
                end
                ST_DIV: if (div_done) begin
                    q_reg[dsel_reg] <= div_quo;
                    if (dsel_reg == 2'd2) begin
                        st_reg <= ST_MAP;
                    end else begin
                        dsel_reg <= dsel_reg + 2'd1;
                        div_start <= 1'b1;
                    end
                end
                ST_MAP: begin
                    mx_reg <= (64'($signed({1'b0, vpw_reg})) * (64'(q_reg[0]) + 64'(ONE))) >>> 1;
                    my_reg <= (64'($signed({1'b0, vph_reg})) * (64'(q_reg[1]) + 64'(ONE))) >>> 1;
                    dz_reg <= ppts_pkg::sat64((64'(q_reg[2]) + 64'(ONE)) >>> 1);
                    st_reg <= ST_CLMP;
                end
                ST_CLMP: begin
                    m_screen_x <= ppts_pkg::sat64(64'(sx_c));
                    m_screen_y <= ppts_pkg::sat64(64'(sy_c));
                    m_depth <= dz_reg; m_w_zero <= 1'b0; m_valid <= 1'b1;
                    st_reg <= ST_OUT;
                end
                ST_OUT: if (m_ready) begin
                    m_valid <= 1'b0; st_reg <= ST_IDLE;
                end
                default: st_reg <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== src/ppts_checker.sv =====
// ----------------------------------------------------------------------------
// ppts_checker
// Port-level checks for point_projection_to_screen_core.
// ----------------------------------------------------------------------------
`default_nettype none
module ppts_checker (
    input wire        aclk,
    input wire        aresetn,
    input wire        s_valid,
    input wire        s_ready,
    input wire        m_valid,
    input wire        m_ready,
    input wire        m_w_zero,
    input wire [31:0] m_screen_x,
    input wire [31:0] m_screen_y
);
    // one word in flight: no input taken while a result waits
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("input taken with result pending");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_screen_x))
        else $error("result dropped");
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_w_zero |-> m_screen_x == 0 && m_screen_y == 0)
        else $error("zero w gave coordinates");
    a_ysgn: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_w_zero && m_screen_y[31] |-> m_screen_y[15:0] == 0)
        else $error("negative y not whole pixel");
endmodule

bind point_projection_to_screen_core ppts_checker u_ppts_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_w_zero(m_w_zero),
    .m_screen_x(m_screen_x), .m_screen_y(m_screen_y)
);
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for point_projection_to_screen_core: matrix row loads and point
// projections are driven with random gaps or back to back, every result word is checked
// against a built-in fixed-point model of both matrix products, the divide,
// the viewport map and the label clamps, under several register settings.
// ----------------------------------------------------------------------------
module tb_top;
    localparam int  FB         = ppts_pkg::FRAC_BITS_DEF;
    localparam longint ONE     = longint'(1) <<< FB;
    localparam int  DRAIN      = 3 * (32 + FB) + 60;
    localparam longint LIMIT   = 3000000;
    localparam logic [31:0] FX_ONE = 32'(ONE);

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] d;
        logic               wz;
    } screen_pos_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_mode = 1'b0;
    logic s_which_matrix = 1'b0;
    logic [1:0] s_row_index = '0;
    logic signed [31:0] s_a0 = '0, s_a1 = '0, s_a2 = '0, s_a3 = '0;
    logic [11:0] s_text_width = '0, s_text_height = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [31:0] m_screen_x, m_screen_y, m_depth;
    logic m_w_zero;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [12:0] cfg_data = '0;

    point_projection_to_screen_core u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_mode(s_mode),
        .s_which_matrix(s_which_matrix), .s_row_index(s_row_index),
        .s_a0(s_a0), .s_a1(s_a1), .s_a2(s_a2), .s_a3(s_a3),
        .s_text_width(s_text_width), .s_text_height(s_text_height),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_screen_x(m_screen_x), .m_screen_y(m_screen_y), .m_depth(m_depth),
        .m_w_zero(m_w_zero),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // model state
    logic signed [31:0] mv_mat [16];
    logic signed [31:0] pj_mat [16];
    logic [12:0] vp_w = 13'd1024, vp_h = 13'd768, sc_w = 13'd1024, sc_h = 13'd768;

    screen_pos_t pending_pos [$];
    int     errors = 0;
    int     n_points = 0, n_loads = 0, n_wzero = 0, n_checked = 0, n_cfg = 0;
    bit     no_idle = 1'b0;
    longint cycles = 0;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycles,
                     pending_pos.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic longint sat32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic screen_pos_t project_point(input logic signed [31:0] px,
            input logic signed [31:0] py, input logic signed [31:0] pz,
            input logic signed [31:0] pw, input logic [11:0] tw, input logic [11:0] th);
        longint vin [4];
        longint eye [4];
        longint clip [4];
        longint acc, sx, sy, dz, half, hi;
        screen_pos_t r;
        vin[0] = px; vin[1] = py; vin[2] = pz; vin[3] = pw;
        for (int i = 0; i < 4; i++) begin
            acc = 0;
            for (int c = 0; c < 4; c++) acc += (longint'(mv_mat[i*4+c]) * vin[c]) >>> FB;
            eye[i] = sat32(acc);
        end
        for (int i = 0; i < 4; i++) begin
            acc = 0;
            for (int c = 0; c < 4; c++) acc += (longint'(pj_mat[i*4+c]) * eye[c]) >>> FB;
            clip[i] = sat32(acc);
        end
        r = '0;
        if (clip[3] == 0) begin
            r.wz = 1'b1;
            return r;
        end
        sx = sat32((clip[0] * ONE) / clip[3]);
        sy = sat32((clip[1] * ONE) / clip[3]);
        dz = sat32((clip[2] * ONE) / clip[3]);
        sx = (longint'(vp_w) * (sx + ONE)) >>> 1;
        sy = (longint'(vp_h) * (sy + ONE)) >>> 1;
        dz = sat32((dz + ONE) >>> 1);
        half = longint'(tw) / 2;
        hi = (longint'(sc_w) - half) * ONE;
        if (sx < half * ONE) sx = half * ONE;
        else if (sx > hi) sx = hi;
        hi = (longint'(sc_h) - 5 * longint'(th)) * ONE;
        if (sy < 0) sy = 0;
        else if (sy > hi) sy = hi;
        r.x = 32'(sat32(sx));
        r.y = 32'(sat32(sy));
        r.d = 32'(dz);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint exp);
        errors++;
        $display("[%0t] mismatch on %s: got %0d expected %0d", $realtime, what, got, exp);
    endtask

    // result checker
    always @(posedge aclk) begin
        screen_pos_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pending_pos.size() == 0) begin
                report_mismatch("unexpected result word", 1, 0);
            end else begin
                e = pending_pos.pop_front();
                n_checked++;
                if (m_w_zero !== e.wz) report_mismatch("w_zero", m_w_zero, e.wz);
                if (m_screen_x !== e.x) report_mismatch("screen_x", m_screen_x, e.x);
                if (m_screen_y !== e.y) report_mismatch("screen_y", m_screen_y, e.y);
                if (m_depth !== e.d) report_mismatch("depth", m_depth, e.d);
            end
        end
    end

    // result side stalls
    initial begin
        int stall;
        @(posedge aresetn);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 8);
            if (stall > 0) begin
                m_ready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready = 1'b1;
            do @(posedge aclk); while (!m_valid);
            @(negedge aclk);
        end
    end

    task automatic send_word(input logic mode, input logic mtx, input logic [1:0] row,
            input logic signed [31:0] v0, input logic signed [31:0] v1,
            input logic signed [31:0] v2, input logic signed [31:0] v3,
            input logic [11:0] tw, input logic [11:0] th);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_mode = mode; s_which_matrix = mtx; s_row_index = row;
        s_a0 = v0; s_a1 = v1; s_a2 = v2; s_a3 = v3;
        s_text_width = tw; s_text_height = th;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        if (mode == ppts_pkg::MODE_LOAD) begin
            n_loads++;
            for (int c = 0; c < 4; c++) begin
                logic signed [31:0] v;
                v = (c == 0) ? v0 : (c == 1) ? v1 : (c == 2) ? v2 : v3;
                if (mtx) pj_mat[row*4+c] = v;
                else mv_mat[row*4+c] = v;
            end
        end else begin
            screen_pos_t e;
            e = project_point(v0, v1, v2, v3, tw, th);
            n_points++;
            if (e.wz) n_wzero++;
            pending_pos = {pending_pos, e};
        end
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    task automatic send_point(input logic signed [31:0] x, input logic signed [31:0] y,
            input logic signed [31:0] z, input logic signed [31:0] w,
            input logic [11:0] tw, input logic [11:0] th);
        send_word(ppts_pkg::MODE_XFRM, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                  x, y, z, w, tw, th);
    endtask

    task automatic wait_idle();
        while (pending_pos.size() != 0) @(negedge aclk);
        repeat (DRAIN) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [12:0] val);
        @(negedge aclk);
        cfg_valid = 1'b1; cfg_index = idx; cfg_data = val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            ppts_pkg::REG_VP_W: vp_w = val;
            ppts_pkg::REG_VP_H: vp_h = val;
            ppts_pkg::REG_SC_W: sc_w = val;
            ppts_pkg::REG_SC_H: sc_h = val;
        endcase
        n_cfg++;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_screen(input logic [12:0] vw, input logic [12:0] vh,
            input logic [12:0] sw, input logic [12:0] sh);
        wait_idle();
        write_reg(ppts_pkg::REG_VP_W, vw);
        write_reg(ppts_pkg::REG_VP_H, vh);
        write_reg(ppts_pkg::REG_SC_W, sw);
        write_reg(ppts_pkg::REG_SC_H, sh);
    endtask

    task automatic load_identity(input logic mtx);
        for (int r = 0; r < 4; r++)
            send_word(ppts_pkg::MODE_LOAD, mtx, r[1:0], (r == 0) ? FX_ONE : 0,
                      (r == 1) ? FX_ONE : 0, (r == 2) ? FX_ONE : 0, (r == 3) ? FX_ONE : 0,
                      0, 0);
    endtask

    function automatic logic signed [31:0] rand_fixed(input bit is_w);
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 10) return $urandom;
        if (sel < 25) return is_w ? 0 : ($urandom_range(0, 1) ? FX_ONE : -FX_ONE);
        if (is_w) return $urandom_range(FX_ONE / 4, 4 * FX_ONE) * ($urandom_range(0, 4) ? 1 : -1);
        return $signed($urandom_range(0, 8 * FX_ONE)) - 4 * FX_ONE;
    endfunction

    // identity and perspective-like matrices, extremes, zero w and crossing clamp bounds
    task automatic test_directed();
        send_point(0, 0, 0, FX_ONE, 0, 0);
        send_point(FX_ONE, FX_ONE, FX_ONE, FX_ONE, 100, 20);
        send_point(-FX_ONE, -FX_ONE, -FX_ONE, FX_ONE, 4095, 4095);
        send_point(0, 0, 0, 0, 10, 10);
        send_point(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 1, 0, 0);
        send_point(32'sh80000000, 32'sh80000000, 32'sh80000000, -1, 4095, 0);
        send_point(FX_ONE / 2, -FX_ONE / 2, FX_ONE / 4, -FX_ONE, 0, 4095);
        send_point(FX_ONE, FX_ONE, 0, 32'sh80000000, 1, 1);
        // perspective-like projection: w takes -z
        send_word(ppts_pkg::MODE_LOAD, 1'b1, 2'd2, 0, 0, -FX_ONE - FX_ONE / 8, -FX_ONE / 4, 0, 0);
        send_word(ppts_pkg::MODE_LOAD, 1'b1, 2'd3, 0, 0, -FX_ONE, 0, 0, 0);
        send_word(ppts_pkg::MODE_LOAD, 1'b0, 2'd3, 0, 0, 0, 32'sh7fffffff, 0, 0);
        send_point(FX_ONE, 2 * FX_ONE, -3 * FX_ONE, FX_ONE, 30, 4);
        send_point(FX_ONE, FX_ONE, 0, FX_ONE, 30, 4);
        send_point(-5 * FX_ONE, FX_ONE, -2 * FX_ONE, FX_ONE, 2000, 200);
        load_identity(1'b0);
        load_identity(1'b1);
        send_point(FX_ONE / 3, FX_ONE / 5, FX_ONE / 7, FX_ONE / 2, 7, 3);
    endtask

    task automatic test_random(input int count);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 3) == 0)
                send_word(ppts_pkg::MODE_LOAD, 1'($urandom_range(0, 1)),
                          2'($urandom_range(0, 3)),
                          rand_fixed(0), rand_fixed(0), rand_fixed(0), rand_fixed(0),
                          12'($urandom), 12'($urandom));
            else
                send_point(rand_fixed(0), rand_fixed(0), rand_fixed(0), rand_fixed(1),
                           $urandom_range(0, 3) ? 12'($urandom_range(0, 200)) : 12'($urandom),
                           $urandom_range(0, 3) ? 12'($urandom_range(0, 60)) : 12'($urandom));
        end
    endtask

    // back-to-back words with no stalls, then a full drain before more traffic
    task automatic test_pressure();
        no_idle = 1'b1;
        test_random(60);
        no_idle = 1'b0;
        while (pending_pos.size() != 0) @(negedge aclk);
        test_random(40);
    endtask

    initial begin
        for (int i = 0; i < 16; i++) begin
            mv_mat[i] = (i % 5 == 0) ? FX_ONE : 0;
            pj_mat[i] = (i % 5 == 0) ? FX_ONE : 0;
        end
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        repeat (DRAIN) @(negedge aclk);

        test_directed();
        set_screen(13'd4096, 13'd4096, 13'd4096, 13'd4096);
        test_directed();
        set_screen(13'd1, 13'd1, 13'd1, 13'd1);
        test_random(350);
        set_screen(13'd4096, 13'd4096, 13'd4096, 13'd4096);
        test_random(350);
        set_screen(13'($urandom_range(1, 4096)), 13'($urandom_range(1, 4096)),
                   13'($urandom_range(1, 4096)), 13'($urandom_range(1, 4096)));
        test_random(350);
        test_pressure();
        set_screen(13'd1024, 13'd768, 13'd1024, 13'd768);
        test_random(350);

        while (pending_pos.size() != 0) @(negedge aclk);
        repeat (DRAIN) @(negedge aclk);
        $display("covered %0d points (%0d with zero w) and %0d matrix row loads,",
                 n_points, n_wzero, n_loads);
        $display("%0d result words checked, %0d register writes, %0d errors",
                 n_checked, n_cfg, errors);
        if (errors == 0 && pending_pos.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
src/ppts_pkg.sv
src/ppts_lane.sv
src/ppts_div.sv
src/point_projection_to_screen_core.sv
src/ppts_checker.sv
tb/tb_top.sv
